// ----- design/escape_time_fractal_pixel_macros.svh -----
// Assertion macros shared by the checkers of the fractal pixel block.
// Every assertion is clocked on clk_i and disabled while rst_ni is low.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fractal pixel assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fractal pixel assertion failed");

`endif

// ----- design/efp_pkg.sv -----
package efp_pkg;

  // Block limits.
  localparam int MAX_SIDE         = 4096;
  localparam int ESCAPE_RADIUS_SQ = 4;

  // Field and datapath widths.
  localparam int PIX_W  = 12;
  localparam int CNT_W  = 16;
  localparam int Z_W    = 32;
  localparam int D_W    = 48;
  localparam int CFG_W  = 32;
  localparam int IDX_W  = 3;
  localparam int OP_W   = 33;
  localparam int PROD_W = 2 * OP_W;
  localparam int SQ_W   = 64;
  localparam int PACC_W = Z_W + D_W;
  localparam int TERM_W = PACC_W - 27;
  localparam int DACC_W = 56;
  localparam int SAT_W  = 48;
  localparam int STEP_W = 4;

  // Escape threshold on |z|^2 in Q8.56.
  localparam logic [SQ_W-1:0] ESC_LIMIT = SQ_W'(ESCAPE_RADIUS_SQ) << 56;

  // 1.0 in Q24.24.
  localparam logic signed [D_W-1:0] ONE_D = 48'sh0000_0100_0000;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_START  = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_START  = 3'd2;
  localparam logic [IDX_W-1:0] REG_X_STEP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_STEP   = 3'd4;
  localparam logic [IDX_W-1:0] REG_JULIA_RE = 3'd5;
  localparam logic [IDX_W-1:0] REG_JULIA_IM = 3'd6;
  localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd7;

  // Mode codes; any other code runs plain Mandelbrot.
  localparam logic [1:0] MODE_CONST_C = 2'd1;
  localparam logic [1:0] MODE_DIST    = 2'd2;

  // Register reset values.
  localparam logic signed [Z_W-1:0] X_START_RST = 32'shE000_0000;
  localparam logic signed [Z_W-1:0] Y_START_RST = 32'shF000_0000;
  localparam logic signed [Z_W-1:0] STEP_RST    = 32'sh0004_0000;
  localparam logic [CNT_W-1:0]      MAX_ITER_RST = 16'd256;

  // Last sequencer step of each phase.
  localparam logic [STEP_W-1:0] POINT_LAST     = 4'd2;
  localparam logic [STEP_W-1:0] ITER_LAST      = 4'd4;
  localparam logic [STEP_W-1:0] ITER_LAST_DIST = 4'd13;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POINT,
    ST_ITER,
    ST_DONE
  } state_e;

  // Multiplier operations. H and L are the high and low halves of a
  // derivative operand in the Q4.28 by Q24.24 products.
  typedef enum logic [3:0] {
    MOP_NONE,
    MOP_PX,
    MOP_PY,
    MOP_RR,
    MOP_II,
    MOP_RI,
    MOP_RDRH,
    MOP_RDRL,
    MOP_IDIH,
    MOP_IDIL,
    MOP_RDIH,
    MOP_RDIL,
    MOP_IDRH,
    MOP_IDRL
  } mop_e;

  // Multiplier schedule while the point is formed.
  function automatic mop_e point_mop(input logic [STEP_W-1:0] step);
    mop_e m;
    case (step)
      4'd0:    m = MOP_PX;
      4'd1:    m = MOP_PY;
      default: m = MOP_NONE;
    endcase
    return m;
  endfunction

  // Multiplier schedule of one iteration.
  function automatic mop_e iter_mop(input logic [STEP_W-1:0] step, input logic dist_on);
    mop_e m;
    case (step)
      4'd0:    m = MOP_RR;
      4'd1:    m = MOP_II;
      4'd2:    m = MOP_RI;
      4'd3:    m = dist_on ? MOP_RDRH : MOP_NONE;
      4'd4:    m = dist_on ? MOP_RDRL : MOP_NONE;
      4'd5:    m = dist_on ? MOP_IDIH : MOP_NONE;
      4'd6:    m = dist_on ? MOP_IDIL : MOP_NONE;
      4'd7:    m = dist_on ? MOP_RDIH : MOP_NONE;
      4'd8:    m = dist_on ? MOP_RDIL : MOP_NONE;
      4'd9:    m = dist_on ? MOP_IDRH : MOP_NONE;
      4'd10:   m = dist_on ? MOP_IDRL : MOP_NONE;
      default: m = MOP_NONE;
    endcase
    return m;
  endfunction

  // Saturate to the signed Q4.28 range.
  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SAT_W-1:0] v);
    logic signed [Z_W-1:0] r;
    if ((v[SAT_W-1:Z_W-1] == '0) || (v[SAT_W-1:Z_W-1] == '1)) begin
      r = v[Z_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Z_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Saturate to the signed Q24.24 range.
  function automatic logic signed [D_W-1:0] sat_d(input logic signed [DACC_W-1:0] v);
    logic signed [D_W-1:0] r;
    if ((v[DACC_W-1:D_W-1] == '0) || (v[DACC_W-1:D_W-1] == '1)) begin
      r = v[D_W-1:0];
    end else if (v[DACC_W-1]) begin
      r = {1'b1, {(D_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(D_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/efp_mul.sv -----
module efp_mul (
  input  logic                               clk_i,
  input  logic signed [efp_pkg::OP_W-1:0]    a_i,
  input  logic signed [efp_pkg::OP_W-1:0]    b_i,
  output logic signed [efp_pkg::PROD_W-1:0]  p_o
);
  import efp_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // Signed multiply with the product registered.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- design/escape_time_fractal_pixel.sv -----
// Escape-time fractal pixel unit. Each request carries a pixel column and
// row; the unit maps it to the point start + index * step (Q4.28), iterates
// z = z*z + c (c is the point in Mandelbrot modes, the configured constant
// in Julia mode) and returns the iteration count, the final z and, in
// distance mode, the derivative d = 2*z*d + 1 in Q24.24. One pixel is in
// work at a time and in_stall_o stays high until its result has moved to
// the output register. All products go through one registered 33x33
// multiplier, which sets the pace: forming the point takes the two index
// products, and each iteration takes the two squares and the cross product,
// then the update, with eight more partial products for the derivative in
// distance mode. The result is then handed over, which waits while the
// output register holds a stalled result, and the unit goes back to idle
// before the next request is taken; an escape costs one pass for its test.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_data_i and
// takes effect at once; it should only change while no pixel is in work.
module escape_time_fractal_pixel (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,

  input  logic                                   cfg_we_i,
  input  logic [efp_pkg::IDX_W-1:0]              cfg_index_i,
  input  logic [efp_pkg::CFG_W-1:0]              cfg_data_i,

  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [efp_pkg::PIX_W-1:0]              pixel_x_i,
  input  logic [efp_pkg::PIX_W-1:0]              pixel_y_i,

  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [efp_pkg::CNT_W-1:0]              iteration_count_o,
  output logic signed [efp_pkg::Z_W-1:0]         final_re_o,
  output logic signed [efp_pkg::Z_W-1:0]         final_im_o,
  output logic signed [efp_pkg::D_W-1:0]         deriv_re_o,
  output logic signed [efp_pkg::D_W-1:0]         deriv_im_o
);
  import efp_pkg::*;

  // Configuration registers.
  logic [1:0]              mode_q;
  logic signed [Z_W-1:0]   x_start_q, y_start_q, x_step_q, y_step_q;
  logic signed [Z_W-1:0]   julia_re_q, julia_im_q;
  logic [CNT_W-1:0]        max_iter_q;

  // Sequencer.
  state_e                  state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [STEP_W-1:0]       last_step;
  mop_e                    mop, mop_q, mop2_q;

  // Datapath registers.
  logic [PIX_W-1:0]        px_q, py_q;
  logic signed [Z_W-1:0]   zr_q, zi_q, cr_q, ci_q;
  logic signed [D_W-1:0]   dr_q, di_q;
  logic signed [SQ_W-1:0]  rr_q, ii_q, ri_q;
  logic signed [PACC_W-1:0] pacc_q;
  logic signed [DACC_W-1:0] dra_q, dia_q;
  logic [CNT_W-1:0]        count_q;

  // Output register.
  logic                    out_valid_q;
  logic [CNT_W-1:0]        cnt_out_q;
  logic signed [Z_W-1:0]   re_out_q, im_out_q;
  logic signed [D_W-1:0]   dre_out_q, dim_out_q;

  // Control strobes.
  logic                    in_req, out_req;
  logic                    update, load_out;
  logic                    julia, dist_mode;

  // Arithmetic.
  logic signed [OP_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [Z_W-1:0]    pt_start;
  logic signed [SAT_W-1:0]  pt_sum;
  logic signed [Z_W-1:0]    pt_sat;
  logic signed [TERM_W-1:0] term;
  logic [SQ_W-1:0]          mag;
  logic                     escaped;
  logic signed [SQ_W-1:0]   sq_diff;
  logic signed [Z_W-1:0]    nzr, nzi;
  logic signed [D_W-1:0]    ndr, ndi;
  logic                     z_zero;
  logic [CNT_W:0]           cnt_inc;
  logic                     limit_hit;

  assign julia     = (mode_q == MODE_CONST_C);
  assign dist_mode = (mode_q == MODE_DIST);
  assign in_req    = in_valid_i && !in_stall_o;
  assign out_req   = out_valid_q && !out_stall_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      x_start_q  <= X_START_RST;
      y_start_q  <= Y_START_RST;
      x_step_q   <= STEP_RST;
      y_step_q   <= STEP_RST;
      julia_re_q <= '0;
      julia_im_q <= '0;
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:     mode_q     <= cfg_data_i[1:0];
        REG_X_START:  x_start_q  <= cfg_data_i;
        REG_Y_START:  y_start_q  <= cfg_data_i;
        REG_X_STEP:   x_step_q   <= cfg_data_i;
        REG_Y_STEP:   y_step_q   <= cfg_data_i;
        REG_JULIA_RE: julia_re_q <= cfg_data_i;
        REG_JULIA_IM: julia_im_q <= cfg_data_i;
        REG_MAX_ITER: max_iter_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Update of one iteration: escape test, next z and next derivative.
  assign mag       = SQ_W'(rr_q[SQ_W-2:0]) + SQ_W'(ii_q[SQ_W-2:0]);
  assign escaped   = (mag >= ESC_LIMIT);
  assign sq_diff   = rr_q - ii_q;
  assign nzr       = sat_z(SAT_W'(sq_diff >>> 28) + SAT_W'(cr_q));
  assign nzi       = sat_z(SAT_W'(ri_q >>> 27) + SAT_W'(ci_q));
  assign ndr       = sat_d(dra_q + DACC_W'(ONE_D));
  assign ndi       = sat_d(dia_q);
  assign z_zero    = (nzr == '0) && (nzi == '0);
  assign cnt_inc   = {1'b0, count_q} + 1'b1;
  assign limit_hit = (cnt_inc == {1'b0, max_iter_q});
  assign last_step = dist_mode ? ITER_LAST_DIST : ITER_LAST;

  // Next state and step.
  always_comb begin
    state_d = state_q;
    step_d  = step_q + 1'b1;
    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (in_req) begin
          state_d = ST_POINT;
        end
      end
      ST_POINT: begin
        if (step_q == POINT_LAST) begin
          step_d  = '0;
          state_d = (max_iter_q == '0) ? ST_DONE : ST_ITER;
        end
      end
      ST_ITER: begin
        if (step_q == last_step) begin
          step_d = '0;
          if (escaped || z_zero || limit_hit) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        step_d = '0;
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    update     = 1'b0;
    load_out   = 1'b0;
    mop        = MOP_NONE;
    case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_POINT: mop = point_mop(step_q);
      ST_ITER: begin
        mop    = iter_mop(step_q, dist_mode);
        update = (step_q == last_step) && !escaped;
      end
      ST_DONE:  load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      mop_q   <= MOP_NONE;
      mop2_q  <= MOP_NONE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mop_q   <= mop;
      mop2_q  <= mop_q;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mop)
      MOP_PX:   begin mul_a = OP_W'(px_q); mul_b = OP_W'(x_step_q); end
      MOP_PY:   begin mul_a = OP_W'(py_q); mul_b = OP_W'(y_step_q); end
      MOP_RR:   begin mul_a = OP_W'(zr_q); mul_b = OP_W'(zr_q); end
      MOP_II:   begin mul_a = OP_W'(zi_q); mul_b = OP_W'(zi_q); end
      MOP_RI:   begin mul_a = OP_W'(zr_q); mul_b = OP_W'(zi_q); end
      MOP_RDRH: begin mul_a = OP_W'(zr_q); mul_b = OP_W'($signed(dr_q[D_W-1:24])); end
      MOP_RDRL: begin mul_a = OP_W'(zr_q); mul_b = OP_W'(dr_q[23:0]); end
      MOP_IDIH: begin mul_a = OP_W'(zi_q); mul_b = OP_W'($signed(di_q[D_W-1:24])); end
      MOP_IDIL: begin mul_a = OP_W'(zi_q); mul_b = OP_W'(di_q[23:0]); end
      MOP_RDIH: begin mul_a = OP_W'(zr_q); mul_b = OP_W'($signed(di_q[D_W-1:24])); end
      MOP_RDIL: begin mul_a = OP_W'(zr_q); mul_b = OP_W'(di_q[23:0]); end
      MOP_IDRH: begin mul_a = OP_W'(zi_q); mul_b = OP_W'($signed(dr_q[D_W-1:24])); end
      MOP_IDRL: begin mul_a = OP_W'(zi_q); mul_b = OP_W'(dr_q[23:0]); end
      default: ;
    endcase
  end

  efp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Point coordinate from the registered index product.
  assign pt_start = (mop_q == MOP_PX) ? x_start_q : y_start_q;
  assign pt_sum   = SAT_W'(pt_start) + SAT_W'(prod);
  assign pt_sat   = sat_z(pt_sum);

  // Floor of a full derivative product divided by 2^27.
  assign term = $signed(pacc_q[PACC_W-1:27]);

  // Datapath: request capture, product handling and iteration update.
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      px_q    <= (32'(pixel_x_i) >= MAX_SIDE) ? PIX_W'(MAX_SIDE - 1) : pixel_x_i;
      py_q    <= (32'(pixel_y_i) >= MAX_SIDE) ? PIX_W'(MAX_SIDE - 1) : pixel_y_i;
      dr_q    <= ONE_D;
      di_q    <= '0;
      count_q <= '0;
    end

    // Products in the cycle after they were issued.
    case (mop_q)
      MOP_PX: begin
        zr_q <= pt_sat;
        cr_q <= julia ? julia_re_q : pt_sat;
      end
      MOP_PY: begin
        zi_q <= pt_sat;
        ci_q <= julia ? julia_im_q : pt_sat;
      end
      MOP_RR: rr_q <= prod[SQ_W-1:0];
      MOP_II: ii_q <= prod[SQ_W-1:0];
      MOP_RI: ri_q <= prod[SQ_W-1:0];
      MOP_RDRH, MOP_IDIH, MOP_RDIH, MOP_IDRH: pacc_q <= PACC_W'(prod) <<< 24;
      MOP_RDRL, MOP_IDIL, MOP_RDIL, MOP_IDRL: pacc_q <= pacc_q + PACC_W'(prod);
      default: ;
    endcase

    // Completed derivative terms, taken from pacc_q once the low partial product has passed the multiplier register.
    case (mop2_q)
      MOP_RDRL: dra_q <= DACC_W'(term);
      MOP_IDIL: dra_q <= dra_q - DACC_W'(term);
      MOP_RDIL: dia_q <= DACC_W'(term);
      MOP_IDRL: dia_q <= dia_q + DACC_W'(term);
      default: ;
    endcase

    // Commit one iteration; landing on zero counts as trapped.
    if (update) begin
      zr_q    <= nzr;
      zi_q    <= nzi;
      count_q <= z_zero ? max_iter_q : cnt_inc[CNT_W-1:0];
      if (dist_mode) begin
        dr_q <= ndr;
        di_q <= ndi;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_req) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      cnt_out_q <= count_q;
      re_out_q  <= zr_q;
      im_out_q  <= zi_q;
      dre_out_q <= dr_q;
      dim_out_q <= di_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign iteration_count_o = cnt_out_q;
  assign final_re_o        = re_out_q;
  assign final_im_o        = im_out_q;
  assign deriv_re_o        = dre_out_q;
  assign deriv_im_o        = dim_out_q;

endmodule

// ----- design/efp_checker.sv -----
`include "escape_time_fractal_pixel_macros.svh"

module efp_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic [efp_pkg::CNT_W-1:0]      iteration_count_o,
  input  logic [efp_pkg::Z_W-1:0]        final_re_o,
  input  logic [efp_pkg::D_W-1:0]        deriv_re_o
);

  // A taken request keeps the unit busy in the following cycle.
  `EFP_ASSERT_NEXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o)

  // No result can appear right after a request is taken.
  `EFP_ASSERT_NEXT(a_no_early_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // A fresh result means the core has gone back to taking requests.
  `EFP_ASSERT_NOW(a_result_frees_core, $rose(out_valid_o), !in_stall_o)

  // A stalled result stays put.
  `EFP_ASSERT_NEXT(a_result_holds, out_valid_o && out_stall_i,
    out_valid_o && $stable(iteration_count_o) && $stable(final_re_o) && $stable(deriv_re_o))

endmodule

bind escape_time_fractal_pixel efp_checker u_efp_checker (.*);

// ----- tb/escape_time_fractal_pixel_tb.sv -----
module escape_time_fractal_pixel_tb;

  // Q4.28 one and the saturation bounds of the two number formats.
  localparam int Q_ONE = 1 << 28;
  localparam longint Z_MAX = 64'sd2147483647;
  localparam longint Z_MIN = -64'sd2147483648;
  localparam longint D_MAX = (64'sd1 <<< 47) - 1;
  localparam longint D_MIN = -(64'sd1 <<< 47);
  localparam longint D_ONE = 64'sd1 <<< 24;
  localparam longint unsigned ESCAPE_BOUND = longint'(efp_pkg::ESCAPE_RADIUS_SQ) << 56;

  // Mode codes that run plain Mandelbrot.
  localparam logic [1:0] MODE_MANDEL     = 2'd0;
  localparam logic [1:0] MODE_MANDEL_ALT = 2'd3;

  typedef enum logic [1:0] {
    PLAN_PIXEL,
    PLAN_WRITE,
    PLAN_DRAIN,
    PLAN_RATES
  } plan_kind_e;

  typedef struct {
    plan_kind_e                  kind;
    logic [efp_pkg::PIX_W-1:0]   px;
    logic [efp_pkg::PIX_W-1:0]   py;
    logic [efp_pkg::IDX_W-1:0]   idx;
    logic [efp_pkg::CFG_W-1:0]   data;
    int                          send_pct;
    int                          recv_pct;
  } plan_step_t;

  typedef struct {
    logic [efp_pkg::CNT_W-1:0]        count;
    logic signed [efp_pkg::Z_W-1:0]   zre;
    logic signed [efp_pkg::Z_W-1:0]   zim;
    logic signed [efp_pkg::D_W-1:0]   dre;
    logic signed [efp_pkg::D_W-1:0]   dim;
  } escape_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          cfg_we = 1'b0;
  logic [efp_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [efp_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [efp_pkg::PIX_W-1:0]     pixel_x = '0;
  logic [efp_pkg::PIX_W-1:0]     pixel_y = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [efp_pkg::CNT_W-1:0]     iteration_count;
  logic signed [efp_pkg::Z_W-1:0] final_re;
  logic signed [efp_pkg::Z_W-1:0] final_im;
  logic signed [efp_pkg::D_W-1:0] deriv_re;
  logic signed [efp_pkg::D_W-1:0] deriv_im;

  // Shadow copy of the configuration registers.
  logic [1:0]                     fr_mode      = MODE_MANDEL;
  logic signed [efp_pkg::Z_W-1:0] fr_x_start   = efp_pkg::X_START_RST;
  logic signed [efp_pkg::Z_W-1:0] fr_y_start   = efp_pkg::Y_START_RST;
  logic signed [efp_pkg::Z_W-1:0] fr_x_step    = efp_pkg::STEP_RST;
  logic signed [efp_pkg::Z_W-1:0] fr_y_step    = efp_pkg::STEP_RST;
  logic signed [efp_pkg::Z_W-1:0] fr_julia_re  = '0;
  logic signed [efp_pkg::Z_W-1:0] fr_julia_im  = '0;
  logic [efp_pkg::CNT_W-1:0]      fr_max_iter  = efp_pkg::MAX_ITER_RST;

  plan_step_t      request_plan_q[$];
  escape_result_t  escape_results_q[$];
  int              pixels_issued = 0;
  int              pixels_returned = 0;
  int              mismatch_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  escape_time_fractal_pixel DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .pixel_x_i         (pixel_x),
    .pixel_y_i         (pixel_y),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .iteration_count_o (iteration_count),
    .final_re_o        (final_re),
    .final_im_o        (final_im),
    .deriv_re_o        (deriv_re),
    .deriv_im_o        (deriv_im)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Exact floor(a * b / 2^27) of a Q4.28 value and a Q24.24 value.
  function automatic longint mul_zd(input longint a, input longint b);
    logic signed [95:0] p;
    p = a;
    p = p * b;
    return longint'(p >>> 27);
  endfunction

  // Escape-time iteration of one pixel under the shadow configuration.
  function automatic escape_result_t predict_escape(input logic [efp_pkg::PIX_W-1:0] px,
                                                    input logic [efp_pkg::PIX_W-1:0] py);
    longint col, row, cr, ci, zr, zi, dr, di, zr2, zi2, nzr, ndr;
    int unsigned iters;
    bit julia, dist_mode;
    escape_result_t r;
    col = px;
    row = py;
    zr = clamp(fr_x_start + col * fr_x_step, Z_MIN, Z_MAX);
    zi = clamp(fr_y_start + row * fr_y_step, Z_MIN, Z_MAX);
    julia = (fr_mode == efp_pkg::MODE_CONST_C);
    dist_mode = (fr_mode == efp_pkg::MODE_DIST);
    cr = julia ? longint'(fr_julia_re) : zr;
    ci = julia ? longint'(fr_julia_im) : zi;
    dr = D_ONE;
    di = 0;
    iters = 0;
    while (iters < fr_max_iter) begin
      zr2 = zr * zr;
      zi2 = zi * zi;
      if ($unsigned(zr2) + $unsigned(zi2) >= ESCAPE_BOUND) break;
      // The derivative uses z from before its update.
      if (dist_mode) begin
        ndr = clamp(mul_zd(zr, dr) - mul_zd(zi, di) + D_ONE, D_MIN, D_MAX);
        di = clamp(mul_zd(zr, di) + mul_zd(zi, dr), D_MIN, D_MAX);
        dr = ndr;
      end
      nzr = clamp(((zr2 - zi2) >>> 28) + cr, Z_MIN, Z_MAX);
      zi = clamp(((zr * zi) >>> 27) + ci, Z_MIN, Z_MAX);
      zr = nzr;
      // Landing exactly on zero counts as trapped.
      if (zr == 0 && zi == 0) begin
        iters = fr_max_iter;
        break;
      end
      iters++;
    end
    r.count = iters[efp_pkg::CNT_W-1:0];
    r.zre = zr[efp_pkg::Z_W-1:0];
    r.zim = zi[efp_pkg::Z_W-1:0];
    r.dre = dist_mode ? dr[efp_pkg::D_W-1:0] : D_ONE[efp_pkg::D_W-1:0];
    r.dim = dist_mode ? di[efp_pkg::D_W-1:0] : '0;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic add_pixel(input int x, input int y);
    plan_step_t s;
    s.kind = PLAN_PIXEL;
    s.px = x[efp_pkg::PIX_W-1:0];
    s.py = y[efp_pkg::PIX_W-1:0];
    request_plan_q.push_back(s);
  endtask

  task automatic add_write(input logic [efp_pkg::IDX_W-1:0] idx,
                           input logic [efp_pkg::CFG_W-1:0] data);
    plan_step_t s;
    s.kind = PLAN_WRITE;
    s.idx = idx;
    s.data = data;
    request_plan_q.push_back(s);
  endtask

  task automatic add_drain();
    plan_step_t s;
    s.kind = PLAN_DRAIN;
    request_plan_q.push_back(s);
  endtask

  task automatic add_rates(input int send_pct, input int recv_pct);
    plan_step_t s;
    s.kind = PLAN_RATES;
    s.send_pct = send_pct;
    s.recv_pct = recv_pct;
    request_plan_q.push_back(s);
  endtask

  // Request driver: holds a pixel request until accepted, issues register
  // writes only once every issued pixel has returned.
  always @(posedge clk) begin : drive_requests
    plan_step_t nxt;
    logic holding, raise, we_next;
    if (rst_n) begin
      holding = in_valid;
      if (in_valid && !in_stall) begin
        escape_results_q.push_back(predict_escape(pixel_x, pixel_y));
        pixels_issued++;
        holding = 1'b0;
      end
      raise = 1'b0;
      we_next = 1'b0;
      if (!holding && request_plan_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt = request_plan_q[0];
        case (nxt.kind)
          PLAN_PIXEL: begin
            pixel_x <= nxt.px;
            pixel_y <= nxt.py;
            raise = 1'b1;
            void'(request_plan_q.pop_front());
          end
          PLAN_WRITE: begin
            if (pixels_issued == pixels_returned) begin
              cfg_index <= nxt.idx;
              cfg_data <= nxt.data;
              we_next = 1'b1;
              case (nxt.idx)
                efp_pkg::REG_MODE:     fr_mode = nxt.data[1:0];
                efp_pkg::REG_X_START:  fr_x_start = nxt.data;
                efp_pkg::REG_Y_START:  fr_y_start = nxt.data;
                efp_pkg::REG_X_STEP:   fr_x_step = nxt.data;
                efp_pkg::REG_Y_STEP:   fr_y_step = nxt.data;
                efp_pkg::REG_JULIA_RE: fr_julia_re = nxt.data;
                efp_pkg::REG_JULIA_IM: fr_julia_im = nxt.data;
                default:               fr_max_iter = nxt.data[efp_pkg::CNT_W-1:0];
              endcase
              void'(request_plan_q.pop_front());
            end
          end
          PLAN_DRAIN: begin
            if (pixels_issued == pixels_returned) void'(request_plan_q.pop_front());
          end
          default: begin
            send_idle_pct <= nxt.send_pct;
            recv_idle_pct <= nxt.recv_pct;
            void'(request_plan_q.pop_front());
          end
        endcase
      end
      in_valid <= holding | raise;
      cfg_we <= we_next;
    end
  end

  // Result monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    escape_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (escape_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual count %0d", $time,
                   iteration_count);
          mismatch_count++;
        end else begin
          want = escape_results_q.pop_front();
          check_field("iteration_count", want.count, iteration_count);
          check_field("final_re", want.zre, final_re);
          check_field("final_im", want.zim, final_im);
          check_field("deriv_re", want.dre, deriv_re);
          check_field("deriv_im", want.dim, deriv_im);
        end
        pixels_returned <= pixels_returned + 1;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : run_plan
    int phase, setting, n;
    logic [1:0] mode_sel;
    logic [efp_pkg::CFG_W-1:0] v;

    add_rates(28, 68);

    // Reset configuration: escape at once, zero trap, minus one trap, interior.
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(2048, 1024);
    add_pixel(1024, 1024);
    add_pixel(1536, 1024);
    add_pixel(2048, 2048);

    // Distance mode, including a derivative that grows into saturation.
    add_write(efp_pkg::REG_MODE, {30'h0, efp_pkg::MODE_DIST});
    add_write(efp_pkg::REG_MAX_ITER, 32'h0000_0030);
    add_pixel(2048, 2048);
    add_pixel(10, 1024);
    add_pixel(2048, 1024);
    add_pixel(0, 0);

    // Zero iteration limit returns the start point; upper data bits ignored.
    add_write(efp_pkg::REG_MAX_ITER, 32'hFFFF_0000);
    add_pixel(1536, 1024);

    // Spare mode code runs as Mandelbrot; largest limit with fast pixels.
    add_write(efp_pkg::REG_MODE, {30'h3FFF_FFFF, MODE_MANDEL_ALT});
    add_write(efp_pkg::REG_MAX_ITER, 32'h1234_FFFF);
    add_pixel(2048, 1024);
    add_pixel(4095, 0);
    add_pixel(1024, 1024);

    // Julia mode with extreme constants drives z into saturation.
    add_write(efp_pkg::REG_MODE, {30'h0, efp_pkg::MODE_CONST_C});
    add_write(efp_pkg::REG_JULIA_RE, 32'h7FFF_FFFF);
    add_write(efp_pkg::REG_JULIA_IM, 32'h8000_0000);
    add_write(efp_pkg::REG_MAX_ITER, 32'h0000_0010);
    add_pixel(2048, 1024);
    add_pixel(3000, 1500);
    add_write(efp_pkg::REG_JULIA_RE, 32'h0000_0000);
    add_write(efp_pkg::REG_JULIA_IM, 32'h0000_0000);
    add_pixel(2048, 1024);
    add_pixel(1024, 1024);

    // Extreme start and step values saturate the mapped point.
    add_write(efp_pkg::REG_MODE, {30'h0, MODE_MANDEL});
    add_write(efp_pkg::REG_X_START, 32'h8000_0000);
    add_write(efp_pkg::REG_Y_START, 32'h7FFF_FFFF);
    add_write(efp_pkg::REG_X_STEP, 32'h7FFF_FFFF);
    add_write(efp_pkg::REG_Y_STEP, 32'h8000_0000);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(1, 1);

    // Random part in three idling phases, each over several configurations.
    for (phase = 0; phase < 3; phase++) begin
      add_drain();
      case (phase)
        0:       add_rates(28, 68);
        1:       add_rates(68, 28);
        default: add_rates(0, 0);
      endcase
      for (setting = 0; setting < 6; setting++) begin
        mode_sel = 2'($urandom_range(3));
        add_write(efp_pkg::REG_MODE, ($urandom() & 32'hFFFF_FFFC) | mode_sel);
        v = ($urandom_range(9) == 0) ? $urandom() :
            -(9 * Q_ONE / 4) + $urandom_range(0, 11 * Q_ONE / 4);
        add_write(efp_pkg::REG_X_START, v);
        v = ($urandom_range(9) == 0) ? $urandom() :
            -(3 * Q_ONE / 2) + $urandom_range(0, 3 * Q_ONE);
        add_write(efp_pkg::REG_Y_START, v);
        v = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 1 << 18);
        if ($urandom_range(3) == 0) v = -v;
        add_write(efp_pkg::REG_X_STEP, v);
        v = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 1 << 18);
        if ($urandom_range(3) == 0) v = -v;
        add_write(efp_pkg::REG_Y_STEP, v);
        v = ($urandom_range(9) == 0) ? $urandom() : -Q_ONE + $urandom_range(0, 2 * Q_ONE);
        add_write(efp_pkg::REG_JULIA_RE, v);
        v = ($urandom_range(9) == 0) ? $urandom() : -Q_ONE + $urandom_range(0, 2 * Q_ONE);
        add_write(efp_pkg::REG_JULIA_IM, v);
        // Distance mode costs more cycles per iteration, so its limit is lower.
        v = (mode_sel == efp_pkg::MODE_DIST) ? $urandom_range(0, 40) : $urandom_range(0, 120);
        add_write(efp_pkg::REG_MAX_ITER, ($urandom() & 32'hFFFF_0000) | v);
        for (n = 0; n < 45; n++) begin
          if ($urandom_range(9) < 7) add_pixel($urandom_range(255), $urandom_range(255));
          else add_pixel($urandom_range(4095), $urandom_range(4095));
          // Now and then hold off until every pending result is back.
          if ($urandom_range(24) == 0) add_drain();
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (request_plan_q.size() != 0 || in_valid || pixels_issued != pixels_returned)
      @(negedge clk);
    repeat (200) @(negedge clk);

    if (mismatch_count == 0 && escape_results_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
